/* src/tcw_pkg.sv */
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_WIDTH  = 8;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_AW = $clog2(CELL_COUNT);

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h0F;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_BACKSP  = 8'h08;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic REG_TEXT_ATTR = 1'b0;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  character;
		logic [10:0] cell_index;
	} tcw_req_t;

	typedef struct packed {
		logic [ROW_W-1:0] cursor_row;
		logic [COL_W-1:0] cursor_col;
		logic [7:0]       cell_char;
		logic [7:0]       cell_attr;
	} tcw_rsp_t;

endpackage

/* src/text_console_writer_unit.sv */
// Put, read and undefined operations pass through the execute and done states and load the result register;
// the next request can be accepted once the unit is back in idle.
// A put that scrolls first copies 24 rows up, then blanks the last row.
// Clear blanks the screen one cell per cycle through the single write port.
// After reset a clearing pass fills the screen; requests are stalled.
// The result register lets the next request enter while a result waits.
module text_console_writer_unit
	import tcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  tcw_req_t    req_data,
	output logic        res_valid,
	input  logic        res_stall,
	output tcw_rsp_t    res_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_SCROLL = 3'd3;
	localparam logic [2:0] S_BLANK  = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	localparam logic [CELL_AW-1:0] CELLS_A = CELL_AW'(CELL_COUNT);
	localparam logic [CELL_AW-1:0] LAST_A  = CELL_AW'(CELL_COUNT - 1);
	localparam logic [CELL_AW-1:0] COLS_A  = CELL_AW'(COLUMNS);
	localparam logic [CELL_AW-1:0] LROW_A  = CELL_AW'(CELL_COUNT - COLUMNS);
	localparam logic [COL_W-1:0]   COLS_C  = COL_W'(COLUMNS);
	localparam logic [COL_W-1:0]   TAB_C   = COL_W'(TAB_WIDTH);
	localparam logic [ROW_W-1:0]   ROWS_C  = ROW_W'(ROWS);

	logic [15:0] mem [CELL_COUNT];

	logic [2:0]         state_q;
	logic [7:0]         attr_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [CELL_AW-1:0] scan_q;
	logic [1:0]         op_q;
	logic [7:0]         ch_q;
	logic [10:0]        idx_q;
	logic [15:0]        rdata_q;
	logic               wr_pend_s1;
	logic [CELL_AW-1:0] wr_addr_s1;
	logic               out_valid_q;
	tcw_rsp_t           out_q;

	logic               mem_we;
	logic [CELL_AW-1:0] mem_waddr;
	logic [15:0]        mem_wdata;
	logic               mem_re;
	logic [CELL_AW-1:0] mem_raddr;

	logic               put_we;
	logic [ROW_W-1:0]   put_row;
	logic [COL_W-1:0]   put_col;
	logic [7:0]         put_char;
	logic [ROW_W-1:0]   nrow;
	logic [COL_W-1:0]   ncol;
	logic [ROW_W-1:0]   wrow;
	logic [COL_W-1:0]   wcol;
	logic [COL_W-1:0]   tab_rem;
	logic               scroll;
	logic               read_ok;
	logic               out_free;
	logic               cfg_wr;

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = out_valid_q;
	assign res_data  = out_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_TEXT_ATTR) ? {24'd0, attr_q} : 32'd0;
	assign cfg_wr    = psel & penable & pwrite & (paddr[2] == REG_TEXT_ATTR);
	assign out_free  = !out_valid_q || !res_stall;
	assign read_ok   = (idx_q < CELLS_A);
	assign tab_rem   = col_q % TAB_C;

	always_comb begin
		nrow     = row_q;
		ncol     = col_q;
		put_we   = 1'b0;
		put_row  = row_q;
		put_col  = col_q;
		put_char = ch_q;
		case (ch_q)
			CH_NEWLINE: begin
				ncol = '0;
				nrow = row_q + ROW_W'(1);
			end
			CH_TAB: begin
				if (tab_rem != '0) begin
					ncol = col_q + (TAB_C - tab_rem);
				end
			end
			CH_BACKSP: begin
				if (col_q != '0) begin
					ncol = col_q - COL_W'(1);
				end else if (row_q != '0) begin
					nrow = row_q - ROW_W'(1);
					ncol = COLS_C - COL_W'(1);
				end
				put_we   = 1'b1;
				put_row  = nrow;
				put_col  = ncol;
				put_char = BLANK_CHAR;
			end
			default: begin
				put_we = 1'b1;
				ncol   = col_q + COL_W'(1);
			end
		endcase
		wrow = nrow;
		wcol = ncol;
		if (ncol >= COLS_C) begin
			wcol = '0;
			wrow = nrow + ROW_W'(1);
		end
		scroll = (wrow >= ROWS_C);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = scan_q;
		mem_wdata = {attr_q, BLANK_CHAR};
		mem_re    = 1'b0;
		mem_raddr = scan_q;
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = {RESET_ATTR, BLANK_CHAR};
			end
			S_BLANK: begin
				mem_we = 1'b1;
			end
			S_EXEC: begin
				mem_we    = put_we && (op_q == OP_PUT);
				mem_waddr = CELL_AW'(put_row) * COLS_A + CELL_AW'(put_col);
				mem_wdata = {attr_q, put_char};
				mem_re    = (op_q == OP_READ) && read_ok;
				mem_raddr = idx_q;
			end
			S_SCROLL: begin
				mem_we    = wr_pend_s1;
				mem_waddr = wr_addr_s1;
				mem_wdata = rdata_q;
				mem_re    = (scan_q < CELLS_A);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			op_q  <= req_data.operation;
			ch_q  <= req_data.character;
			idx_q <= req_data.cell_index;
		end
		if (state_q == S_DONE && out_free) begin
			out_q.cursor_row <= row_q;
			out_q.cursor_col <= col_q;
			out_q.cell_char  <= (op_q == OP_READ && read_ok) ? rdata_q[7:0] : 8'd0;
			out_q.cell_attr  <= (op_q == OP_READ && read_ok) ? rdata_q[15:8] : 8'd0;
		end
		wr_addr_s1 <= scan_q - COLS_A;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			attr_q      <= RESET_ATTR;
			row_q       <= '0;
			col_q       <= '0;
			scan_q      <= '0;
			wr_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				attr_q <= pwdata[7:0];
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			wr_pend_s1 <= (state_q == S_SCROLL) && (scan_q < CELLS_A);
			case (state_q)
				S_INIT: begin
					scan_q <= scan_q + CELL_AW'(1);
					if (scan_q == LAST_A) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						OP_PUT: begin
							col_q <= wcol;
							if (scroll) begin
								row_q   <= ROW_W'(ROWS - 1);
								scan_q  <= COLS_A;
								state_q <= S_SCROLL;
							end else begin
								row_q   <= wrow;
								state_q <= S_DONE;
							end
						end
						OP_CLEAR: begin
							row_q   <= '0;
							col_q   <= '0;
							scan_q  <= '0;
							state_q <= S_BLANK;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SCROLL: begin
					if (scan_q < CELLS_A) begin
						scan_q <= scan_q + CELL_AW'(1);
					end else begin
						scan_q  <= LROW_A;
						state_q <= S_BLANK;
					end
				end
				S_BLANK: begin
					scan_q <= scan_q + CELL_AW'(1);
					if (scan_q == LAST_A) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (row_q < ROWS_C && col_q < COLS_C))
		else $error("cursor out of range");

	a_scroll_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCROLL) |-> (scan_q >= COLS_A))
		else $error("scroll read above second row");

	a_scroll_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> (state_q == S_SCROLL && wr_addr_s1 < LROW_A))
		else $error("scroll write outside copy region");

	a_result_row: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.cursor_row < ROWS_C && res_data.cursor_col < COLS_C))
		else $error("result cursor out of range");
`endif

endmodule
